FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: hw/rtl/tld_pkg.sv
// ---------------------------------------------------------------------------
// tld_pkg
// Types, constants and helpers for the terminal line discipline.
// ---------------------------------------------------------------------------
package tld_pkg;
    localparam int RX_DEPTH_DEF = 256;
    localparam int TX_DEPTH_DEF = 16;

    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_TXRDY = 2'd3;

    localparam logic [2:0] REG_IMODE = 3'd0;
    localparam logic [2:0] REG_LMODE = 3'd1;
    localparam logic [2:0] REG_OMODE = 3'd2;
    localparam logic [2:0] REG_ERASE = 3'd3;
    localparam logic [2:0] REG_KILL  = 3'd4;
    localparam logic [2:0] REG_WERASE = 3'd5;

    localparam logic [7:0] C_BEL  = 8'h07;
    localparam logic [7:0] C_BS   = 8'h08;
    localparam logic [7:0] C_TAB  = 8'h09;
    localparam logic [7:0] C_NL   = 8'h0A;
    localparam logic [7:0] C_CR   = 8'h0D;
    localparam logic [7:0] C_XON  = 8'h11;
    localparam logic [7:0] C_XOFF = 8'h13;
    localparam logic [7:0] C_SP   = 8'h20;
    localparam logic [7:0] C_CARET = 8'h5E;
    localparam logic [7:0] C_DEL  = 8'h7F;
    localparam logic [7:0] CTL_FLIP = 8'h40;

    // stop rule of an erase walk
    localparam logic [1:0] STOP_NEVER  = 2'd0;
    localparam logic [1:0] STOP_NONSP  = 2'd1;
    localparam logic [1:0] STOP_SP     = 2'd2;

    typedef struct packed {
        logic       line_out_valid;
        logic [7:0] line_out_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       write_accepted;
        logic       output_halted;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture item, preprocess
        logic       rx_rd;     // issue rx memory read of previous entry
        logic       erase_try; // evaluate erase of fetched entry
        logic [1:0] stop;
        logic       kill;
        logic       finish;    // finishing action of the item
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       is_rx;
        logic       is_kill;
        logic       is_werase;
        logic       is_erase;
        logic       erased;
    } t_stat;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c < C_SP || c == C_DEL) && c != C_TAB && c != C_NL &&
               c != C_XON && c != C_XOFF;
    endfunction
endpackage

FILE: hw/rtl/tld_if.sv
// ---------------------------------------------------------------------------
// tld_if
// Valid/ready channel interfaces: items, results and register writes.
// ---------------------------------------------------------------------------
interface tld_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    modport source(output valid, opcode, data_byte, input ready);
    modport sink(input valid, opcode, data_byte, output ready);
endinterface

interface tld_result_if;
    logic       valid;
    logic       ready;
    logic       line_out_valid;
    logic [7:0] line_out_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_accepted;
    logic       output_halted;
    modport source(output valid, line_out_valid, line_out_byte, read_valid, read_byte,
                   write_accepted, output_halted, input ready);
    modport sink(input valid, line_out_valid, line_out_byte, read_valid, read_byte,
                 write_accepted, output_halted, output ready);
endinterface

interface tld_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tty_line_discipline_core.sv
// ---------------------------------------------------------------------------
// tty_line_discipline_core
// Terminal line discipline between a serial line and an application.
// ---------------------------------------------------------------------------
// channel   dir  payload
// item      in   opcode, data_byte
// result    out  line_out_valid/byte, read_valid/byte, write_accepted, halted
// cfg       in   index, data
// An item passes accept, decode, finish and result. An erase adds a fetch and
// a test of the last character. A kill adds a fetch and test per character
// removed plus the fetch and test that end the walk; a word erase walks twice, the
// same way, with a return to decode between the walks.
// Reset is synchronous; all pointers and counters clear, memories do not.
// The result holds until taken; the next item is accepted after that.
`include "assert_macros.svh"
module tty_line_discipline_core
    import tld_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    tld_item_if.sink     in_ch,
    tld_result_if.source out_ch,
    tld_cfg_if.sink      cfg_ch
);
    t_cmd    cmd;
    t_stat   stat;
    t_result res;

    assign cfg_ch.ready = 1'b1;

    tld_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    tld_dp #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_opcode(in_ch.opcode), .i_data_byte(in_ch.data_byte),
        .i_cfg_we(cfg_ch.valid), .i_cfg_index(cfg_ch.index), .i_cfg_data(cfg_ch.data),
        .i_cmd(cmd), .o_stat(stat), .o_result(res)
    );

    assign out_ch.line_out_valid = res.line_out_valid;
    assign out_ch.line_out_byte = res.line_out_byte;
    assign out_ch.read_valid = res.read_valid;
    assign out_ch.read_byte = res.read_byte;
    assign out_ch.write_accepted = res.write_accepted;
    assign out_ch.output_halted = res.output_halted;

    `ASSERT_NEVER(a_no_overlap, i_clk, i_rst_n, in_ch.ready && out_ch.valid)
    `ASSERT_IMPL(a_load_then_busy, i_clk, i_rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    `ASSERT_IMPL(a_line_byte_zero, i_clk, i_rst_n,
        (out_ch.valid && !out_ch.line_out_valid) |-> (out_ch.line_out_byte == 8'h00))
endmodule

FILE: hw/rtl/tld_ctrl.sv
// ---------------------------------------------------------------------------
// tld_ctrl
// Sequencer: accepts an item, runs erase walks, delivers the result.
// ---------------------------------------------------------------------------
module tld_ctrl
    import tld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PRE   = 6'b000010,
        S_FETCH = 6'b000100,
        S_EVAL  = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass2, n_pass2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass2 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass2 <= n_pass2;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass2 = r_pass2;
        o_cmd = '0;
        o_cmd.kill = i_stat.is_kill;
        o_cmd.stop = i_stat.is_werase ? (r_pass2 ? STOP_SP : STOP_NONSP) : STOP_NEVER;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_pass2 = 1'b0;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (i_stat.is_rx && (i_stat.is_erase || i_stat.is_kill || i_stat.is_werase)) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FETCH: begin
                o_cmd.rx_rd = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.erase_try = 1'b1;
                if (i_stat.erased && !i_stat.is_erase) begin
                    n_state = S_FETCH;
                end else if (i_stat.is_werase && !r_pass2) begin
                    n_pass2 = 1'b1;
                    n_state = S_PRE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

FILE: hw/rtl/tld_dp.sv
// ---------------------------------------------------------------------------
// tld_dp
// Datapath: registers, receive and transmit queues, echo and output logic.
// ---------------------------------------------------------------------------
module tld_dp
    import tld_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output t_result    o_result
);
    localparam int RW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TW = $clog2(TX_DEPTH);

    logic [5:0] r_imode;
    logic [6:0] r_lmode;
    logic [2:0] r_omode;
    logic [7:0] r_erase_c, r_kill_c, r_werase_c;

    logic [7:0]    r_rx_mem [RX_DEPTH];
    logic [7:0]    r_tx_mem [TX_DEPTH];
    logic [RW-1:0] r_rx_rp, r_rx_wp;
    logic [TW-1:0] r_tx_rp, r_tx_wp;
    logic [7:0]    r_lines, r_backlog;
    logic [1:0]    r_phase;
    logic          r_halted, r_plf;
    logic [7:0]    r_rx_q, r_tx_q;
    logic [1:0]    r_op;
    logic [7:0]    r_d;
    t_result       r_res;

    function automatic logic [RW-1:0] rx_nx(input logic [RW-1:0] p);
        return (32'(p) + 1 >= RX_DEPTH) ? '0 : RW'(32'(p) + 1);
    endfunction
    function automatic logic [RW-1:0] rx_pv(input logic [RW-1:0] p);
        return (p == '0) ? RW'(RX_DEPTH - 1) : p - 1'b1;
    endfunction
    function automatic logic [TW-1:0] tx_nx(input logic [TW-1:0] p);
        return (32'(p) + 1 >= TX_DEPTH) ? '0 : TW'(32'(p) + 1);
    endfunction
    function automatic logic [TW-1:0] tx_pv(input logic [TW-1:0] p);
        return (p == '0) ? TW'(TX_DEPTH - 1) : p - 1'b1;
    endfunction

    logic canon, f_echo, f_echoe, f_echok, f_echoctl, f_echonl, f_onlcr, f_ocrnl;
    assign canon = r_lmode[0];
    assign f_echo = r_lmode[2];
    assign f_echoe = f_echo && r_lmode[3];
    assign f_echok = f_echo && r_lmode[4];
    assign f_echoctl = f_echo && r_lmode[5];
    assign f_echonl = r_lmode[6];
    assign f_onlcr = r_omode[0] && r_omode[1];
    assign f_ocrnl = r_omode[0] && r_omode[2];

    // preprocessing of a received byte (from captured raw byte)
    logic [7:0] pd, er, kl, we;
    logic       p_drop, p_xoff, p_xon;
    always_comb begin
        pd = r_d;
        p_xoff = r_imode[4] && r_d == C_XOFF;
        p_xon = r_imode[4] && r_d == C_XON;
        if (r_imode[0]) pd = pd & 8'h7F;
        p_drop = p_xoff || p_xon || (r_imode[1] && pd == C_CR);
        if (r_imode[2] && pd == C_CR) pd = C_NL;
        else if (r_imode[3] && pd == C_NL) pd = C_CR;
        er = canon ? r_erase_c : 8'h00;
        kl = canon ? r_kill_c : 8'h00;
        we = (canon && r_lmode[1]) ? r_werase_c : 8'h00;
    end

    logic s_erase, s_kill, s_werase;
    assign s_erase = er != 8'h00 && (pd == C_BS || pd == er);
    assign s_kill = !s_erase && kl != 8'h00 && pd == kl;
    assign s_werase = !s_erase && !s_kill && we != 8'h00 && pd == we;

    // erase evaluation of fetched entry r_rx_q
    logic ev_ok;
    always_comb begin
        ev_ok = r_rx_wp != r_rx_rp && r_rx_q != C_NL &&
                !(i_cmd.stop == STOP_NONSP && r_rx_q != C_SP) &&
                !(i_cmd.stop == STOP_SP && r_rx_q == C_SP);
    end

    assign o_stat.is_rx = r_op == OP_RX && !p_drop;
    assign o_stat.is_erase = s_erase;
    assign o_stat.is_kill = s_kill;
    assign o_stat.is_werase = s_werase;
    assign o_stat.erased = ev_ok;

    // finishing: queue push / echo / tx-ready / read / write
    logic          tx_full;
    logic [TW-1:0] tx_n1;
    assign tx_n1 = tx_nx(r_tx_wp);
    assign tx_full = tx_n1 == r_tx_rp;

    logic          rx_ok, do_store, do_echo, echo_nl, echo_ctl, echo_pl, bell;
    logic [RW-1:0] rx_n;
    always_comb begin
        rx_n = rx_nx(r_rx_wp);
        rx_ok = rx_n != r_rx_rp && (!canon || pd == C_NL || rx_nx(rx_n) != r_rx_rp);
        do_store = o_stat.is_rx && !s_erase && !s_kill && !s_werase && rx_ok;
        bell = o_stat.is_rx && !s_erase && !s_kill && !s_werase && !rx_ok && r_imode[5];
        do_echo = do_store || (o_stat.is_rx && ((s_erase && !f_echoe) ||
                  (s_kill && !f_echok) || (s_werase && !f_echoe)));
        echo_nl = (f_echo || f_echonl) && pd == C_NL;
        echo_ctl = !echo_nl && f_echoctl && is_ctl(pd);
        echo_pl = !echo_nl && !echo_ctl && f_echo;
    end

    // transmitter ready
    logic       t_send, t_pop, t_plf_clr, t_plf_set, t_bl_dec;
    logic [1:0] t_phase;
    logic [7:0] t_byte, t_d;
    always_comb begin
        t_send = 1'b0; t_pop = 1'b0; t_plf_clr = 1'b0; t_plf_set = 1'b0;
        t_bl_dec = 1'b0; t_phase = r_phase; t_byte = 8'h00; t_d = r_tx_q;
        if (r_imode[4] && r_halted) begin
            t_send = 1'b0;
        end else if (f_onlcr && r_plf) begin
            t_plf_clr = 1'b1; t_send = 1'b1; t_byte = C_NL;
        end else if ((f_echoe || f_echok) && (r_phase != 2'd0 || r_backlog != 8'h00)) begin
            t_send = 1'b1;
            unique case (r_phase)
                2'd0: begin t_bl_dec = 1'b1; t_phase = 2'd2; t_byte = C_BS; end
                2'd1: begin t_phase = 2'd2; t_byte = C_BS; end
                2'd2: begin t_phase = 2'd3; t_byte = C_SP; end
                2'd3: begin t_phase = 2'd0; t_byte = C_BS; end
                default: t_phase = 2'd0;
            endcase
        end else if (r_tx_rp != r_tx_wp) begin
            t_send = 1'b1; t_pop = 1'b1;
            if (f_ocrnl && t_d == C_CR) t_d = C_NL;
            if (f_onlcr && t_d == C_NL) begin t_d = C_CR; t_plf_set = 1'b1; end
            t_byte = t_d;
        end
    end

    logic rd_ok;
    assign rd_ok = !(canon && r_lines == 8'h00) && r_rx_rp != r_rx_wp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_rd) r_rx_q <= r_rx_mem[rx_pv(r_rx_wp)];
        else r_rx_q <= r_rx_mem[r_rx_rp];
        r_tx_q <= r_tx_mem[r_tx_rp];
    end

    // tx queue write port (one push per cycle, none while full; echo of ^X as caret, then the letter in r_second_b)
    logic          tx_we;
    logic [7:0]    tx_wd;
    logic          r_second;
    logic [7:0]    r_second_b;

    always_ff @(posedge i_clk) begin
        if (tx_we) r_tx_mem[r_tx_wp] <= tx_wd;
        if (i_cmd.finish && do_store) r_rx_mem[r_rx_wp] <= pd;
    end

    logic withdraw_need;
    logic [1:0] withdraw_cnt;

    always_comb begin
        tx_we = 1'b0;
        tx_wd = 8'h00;
        if (r_second) begin
            tx_we = !tx_full; tx_wd = r_second_b;
        end else if (i_cmd.finish) begin
            if (r_op == OP_WRITE) begin
                tx_we = !tx_full; tx_wd = r_d;
            end else if (bell) begin
                tx_we = !tx_full; tx_wd = C_BEL;
            end else if (do_echo) begin
                if (echo_nl) begin tx_we = !tx_full; tx_wd = C_NL; end
                else if (echo_ctl) begin tx_we = !tx_full; tx_wd = C_CARET; end
                else if (echo_pl) begin tx_we = !tx_full; tx_wd = pd; end
            end
        end
        withdraw_need = i_cmd.erase_try && ev_ok &&
                        ((f_echok && i_cmd.kill) || (f_echoe && !i_cmd.kill));
        withdraw_cnt = (f_echoctl && is_ctl(r_rx_q)) ? 2'd2 : 2'd1;
    end

    // two-step withdraw handled arithmetically
    logic [TW:0]   tx_used;
    logic [1:0]    wd_n;
    logic [1:0]    bl_n;
    always_comb begin
        tx_used = (r_tx_wp >= r_tx_rp) ? {1'b0, r_tx_wp - r_tx_rp}
                                       : (TW+1)'(TX_DEPTH) - {1'b0, r_tx_rp - r_tx_wp};
        wd_n = (tx_used >= (TW+1)'(withdraw_cnt)) ? withdraw_cnt : tx_used[1:0];
        bl_n = withdraw_cnt - wd_n;
    end

    logic [TW-1:0] tx_wp_wd;
    assign tx_wp_wd = (wd_n == 2'd2) ? tx_pv(tx_pv(r_tx_wp)) :
                      (wd_n == 2'd1) ? tx_pv(r_tx_wp) : r_tx_wp;

    logic [8:0] bl_sum;
    assign bl_sum = {1'b0, r_backlog} + 9'(bl_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imode <= 6'd52; r_lmode <= 7'd63; r_omode <= 3'd3;
            r_erase_c <= 8'd127; r_kill_c <= 8'd21; r_werase_c <= 8'd23;
            r_rx_rp <= '0; r_rx_wp <= '0; r_tx_rp <= '0; r_tx_wp <= '0;
            r_lines <= '0; r_backlog <= '0; r_phase <= '0;
            r_halted <= 1'b0; r_plf <= 1'b0; r_second <= 1'b0;
            r_op <= OP_RX;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_IMODE: r_imode <= i_cfg_data[5:0];
                    REG_LMODE: r_lmode <= i_cfg_data[6:0];
                    REG_OMODE: r_omode <= i_cfg_data[2:0];
                    REG_ERASE: r_erase_c <= i_cfg_data;
                    REG_KILL: r_kill_c <= i_cfg_data;
                    REG_WERASE: r_werase_c <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_op <= i_opcode;
                r_res <= '0;
            end
            if (tx_we) r_tx_wp <= tx_n1;
            r_second <= 1'b0;
            if (i_cmd.erase_try && ev_ok) begin
                r_rx_wp <= rx_pv(r_rx_wp);
                if (withdraw_need) begin
                    r_tx_wp <= tx_wp_wd;
                    r_backlog <= (bl_sum > 9'd255) ? 8'd255 : bl_sum[7:0];
                end
            end
            if (i_cmd.finish) begin
                if (r_op == OP_RX) begin
                    if (p_xoff) r_halted <= 1'b1;
                    if (p_xon) r_halted <= 1'b0;
                    if (do_store) begin
                        r_rx_wp <= rx_n;
                        if (canon && pd == C_NL) r_lines <= r_lines + 8'd1;
                    end
                    if (do_echo && echo_ctl && !tx_full) begin
                        r_second <= 1'b1;
                        r_second_b <= pd ^ CTL_FLIP;
                    end
                end
                if (r_op == OP_WRITE) r_res.write_accepted <= !tx_full;
                if (r_op == OP_READ && rd_ok) begin
                    r_res.read_valid <= 1'b1;
                    r_res.read_byte <= r_rx_q;
                    r_rx_rp <= rx_nx(r_rx_rp);
                    if (canon && r_rx_q == C_NL) r_lines <= r_lines - 8'd1;
                end
                if (r_op == OP_TXRDY) begin
                    r_res.line_out_valid <= t_send;
                    r_res.line_out_byte <= t_byte;
                    if (t_plf_clr) r_plf <= 1'b0;
                    if (t_plf_set) r_plf <= 1'b1;
                    if (t_bl_dec) r_backlog <= r_backlog - 8'd1;
                    r_phase <= t_phase;
                    if (t_pop) r_tx_rp <= tx_nx(r_tx_rp);
                end
            end
            if (i_cmd.load) r_d <= i_data_byte;
        end
    end

    always_comb begin
        o_result = r_res;
        o_result.output_halted = r_halted;
    end
endmodule
